// ===== src/rsse_pkg.sv =====
// Package for the Reed-Solomon systematic encoder: field size, parity limits,
// shared types, register indexes, generator sequencer states and GF(2^m) helpers.
// Used by the top and the generator sequencer; depends on nothing.
package rsse_pkg;

   localparam int SYM_BITS   = 8;
   localparam int MAX_PARITY = 32;

   localparam int NN        = (1 << SYM_BITS) - 1;
   localparam int N_MAX     = (MAX_PARITY < NN - 1) ? MAX_PARITY : NN - 1;
   localparam int N_BITS    = $clog2(N_MAX + 1);
   localparam int CSR_BITS  = 2;

   localparam logic [7:0] FIELD_POLY_RESET   = 8'd29;
   localparam logic [7:0] FIRST_ROOT_RESET   = 8'd0;
   localparam logic [7:0] ROOT_STEP_RESET    = 8'd1;
   localparam logic [5:0] PARITY_COUNT_RESET = 6'd16;

   typedef logic [SYM_BITS-1:0] sym_type;
   typedef logic [MAX_PARITY-1:0][SYM_BITS-1:0] sym_array_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_FIELD_POLY,
      CSR_FIRST_ROOT,
      CSR_ROOT_STEP,
      CSR_PARITY_COUNT
   } csr_index_type;

   typedef enum logic [2:0] {
      GEN_IDLE,
      GEN_PROD,
      GEN_REDUCE,
      GEN_POW,
      GEN_POLY
   } gen_state_type;

   typedef struct packed {
      logic [7:0] field_poly;
      logic [7:0] first_root;
      logic [7:0] root_step;
      logic [5:0] parity_count;
   } gen_cfg_type;

   typedef struct packed {
      logic              busy;
      logic [N_BITS-1:0] n;
   } gen_status_type;

   function automatic sym_type gf_xtime(input sym_type a, input sym_type fp);
      sym_type sh;
      sh = {a[SYM_BITS-2:0], 1'b0};
      return a[SYM_BITS-1] ? (sh ^ fp) : sh;
   endfunction

   function automatic sym_type gf_mul(input sym_type a, input sym_type b, input sym_type fp);
      sym_type acc;
      sym_type x;
      acc = '0;
      x   = a;
      for (int k = 0; k < SYM_BITS; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         x = gf_xtime(x, fp);
      end
      return acc;
   endfunction

endpackage

// ===== src/reed_solomon_systematic_encoder_top.sv =====
// Top level of the systematic Reed-Solomon encoder over GF(2^m).
// Depends on rsse_pkg and rsse_gen.
//
// Usage: data symbols enter on the req_ stream, one per beat. Each one leaves
// on the rsp_ stream in the cycle after it is accepted, with rsp_tuser low.
// After the (NN - n)-th data beat of a codeword the n parity beats follow,
// one per cycle while the receiver takes them, highest degree first, with
// rsp_tuser high and rsp_tlast on the final one. During data, one symbol is
// taken every cycle unless the receiver stalls; req_tready is low while the
// parity beats drain.
// The csr_ port writes the field polynomial, first root, root step and
// parity count. At reset, and at the start of the first codeword after any
// write, the generator sequencer runs with req_tready low, stepping through
// its product, reduce, power and polynomial states. Writes in mid-codeword
// apply to the next codeword, except that the field polynomial feeds the
// parity update at once.
// When the receiver stalls, the output register holds its beat and
// req_tready drops until it is taken.
module reed_solomon_systematic_encoder_top import rsse_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_symbol
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] out_symbol
   output logic [0:0]          rsp_tuser,   // [0] is_parity
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_index,
   input  logic [7:0]          csr_wdata
);

   logic [7:0]        field_poly_ff, first_root_ff, root_step_ff;
   logic [5:0]        parity_count_ff;
   logic              dirty_ff, dirty_in;
   sym_type           count_ff, count_in;
   logic [N_BITS-1:0] drain_ff, drain_in;
   sym_array_type     par_ff, par_in, par_lfsr, par_shift;
   logic              rsp_valid_ff, rsp_valid_in;
   sym_type           out_sym_ff, out_sym_in;
   logic              out_par_ff, out_par_in;
   logic              out_last_ff, out_last_in;

   gen_cfg_type       gen_cfg;
   gen_status_type    gen_status;
   sym_array_type     taps;
   logic              gen_start;

   sym_type           sym, fb, fp_live;
   logic              accept, last_data, out_free, draining, hold_start;

   assign gen_cfg.field_poly   = field_poly_ff;
   assign gen_cfg.first_root   = first_root_ff;
   assign gen_cfg.root_step    = root_step_ff;
   assign gen_cfg.parity_count = parity_count_ff;

   rsse_gen u_gen (
      .clock  (clock),
      .reset  (reset),
      .start  (gen_start),
      .cfg    (gen_cfg),
      .status (gen_status),
      .taps   (taps)
   );

   assign sym     = req_tdata[SYM_BITS-1:0];
   assign fp_live = field_poly_ff[SYM_BITS-1:0];
   assign fb      = sym ^ par_ff[0];

   always_comb begin
      for (int m = 0; m < MAX_PARITY - 1; m++) begin
         par_lfsr[m]  = par_ff[m+1] ^ gf_mul(fb, taps[m], fp_live);
         par_shift[m] = par_ff[m+1];
      end
      par_lfsr[MAX_PARITY-1]  = gf_mul(fb, taps[MAX_PARITY-1], fp_live);
      par_shift[MAX_PARITY-1] = '0;
   end

   assign last_data  = (count_ff == (sym_type'(NN - 1) - sym_type'(gen_status.n)));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign draining   = (drain_ff != '0);
   assign hold_start = dirty_ff && (count_ff == '0);
   assign gen_start  = !gen_status.busy && hold_start;
   assign req_tready = !gen_status.busy && !hold_start && !draining && out_free;
   assign accept     = req_tvalid && req_tready;
   assign dirty_in   = csr_we ? 1'b1 : (gen_start ? 1'b0 : dirty_ff);

   always_comb begin
      count_in     = count_ff;
      drain_in     = drain_ff;
      par_in       = par_ff;
      rsp_valid_in = rsp_valid_ff;
      out_sym_in   = out_sym_ff;
      out_par_in   = out_par_ff;
      out_last_in  = out_last_ff;
      if (accept) begin
         par_in       = par_lfsr;
         count_in     = last_data ? '0 : count_ff + sym_type'(1);
         if (last_data) begin
            drain_in = gen_status.n;
         end
         rsp_valid_in = 1'b1;
         out_sym_in   = sym;
         out_par_in   = 1'b0;
         out_last_in  = 1'b0;
      end else if (draining && out_free) begin
         par_in       = par_shift;
         drain_in     = drain_ff - N_BITS'(1);
         rsp_valid_in = 1'b1;
         out_sym_in   = par_ff[0];
         out_par_in   = 1'b1;
         out_last_in  = (drain_ff == N_BITS'(1));
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_poly_ff   <= FIELD_POLY_RESET;
         first_root_ff   <= FIRST_ROOT_RESET;
         root_step_ff    <= ROOT_STEP_RESET;
         parity_count_ff <= PARITY_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_POLY:   field_poly_ff   <= csr_wdata;
            CSR_FIRST_ROOT:   first_root_ff   <= csr_wdata;
            CSR_ROOT_STEP:    root_step_ff    <= csr_wdata;
            CSR_PARITY_COUNT: parity_count_ff <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff     <= 1'b1;
         count_ff     <= '0;
         drain_ff     <= '0;
         par_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dirty_ff     <= dirty_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         par_ff       <= par_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sym_ff  <= out_sym_in;
      out_par_ff  <= out_par_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = 8'(out_sym_ff);
   assign rsp_tuser[0] = out_par_ff;
   assign rsp_tlast    = out_last_ff;

endmodule

// ===== src/rsse_gen.sv =====
// Generator polynomial sequencer: derives the LFSR tap coefficients and the
// active parity count from a configuration snapshot taken at start.
// Depends on rsse_pkg.
module rsse_gen import rsse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  gen_cfg_type    cfg,
   output gen_status_type status,
   output sym_array_type  taps
);

   localparam int FOLDS = 16 / SYM_BITS + 2;
   localparam int PW    = 2 * SYM_BITS;

   function automatic sym_type mod_nn(input logic [15:0] v);
      logic [15:0] acc;
      acc = v;
      for (int k = 0; k < FOLDS; k++) begin
         acc = (acc & 16'(NN)) + (acc >> SYM_BITS);
      end
      if (acc == 16'(NN)) begin
         acc = '0;
      end
      return acc[SYM_BITS-1:0];
   endfunction

   function automatic logic [N_BITS-1:0] clamp_n(input logic [5:0] pc);
      logic [6:0] c;
      c = {1'b0, pc};
      if (c == 7'd0) begin
         c = 7'd1;
      end
      if (int'(c) > N_MAX) begin
         c = 7'(N_MAX);
      end
      return N_BITS'(c);
   endfunction

   gen_state_type     state_ff, state_in;
   sym_type           fp_ff, es_ff, ef_ff, er_ff, k_ff, spow_ff, root_ff;
   logic [PW-1:0]     prod_ff;
   logic [N_BITS-1:0] n_ff, i_ff, active_n_ff;
   sym_array_type     taps_ff, taps_in;
   logic              pow_done;

   // The tap array holds the reversed generator without its leading one, so
   // multiplying by (x + root) becomes r[k] ^= root * r[k-1].
   always_comb begin
      taps_in[0] = taps_ff[0] ^ root_ff;
      for (int m = 1; m < MAX_PARITY; m++) begin
         taps_in[m] = taps_ff[m] ^ gf_mul(root_ff, taps_ff[m-1], fp_ff);
      end
   end

   assign pow_done = (k_ff >= es_ff) && (k_ff >= er_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         GEN_IDLE: begin
            if (start) begin
               state_in = GEN_PROD;
            end
         end
         GEN_PROD:   state_in = GEN_REDUCE;
         GEN_REDUCE: state_in = GEN_POW;
         GEN_POW: begin
            if (pow_done) begin
               state_in = GEN_POLY;
            end
         end
         GEN_POLY: begin
            if (i_ff == n_ff) begin
               state_in = GEN_IDLE;
            end
         end
         default:    state_in = GEN_IDLE;
      endcase
   end

   always_comb begin
      status.busy = (state_ff != GEN_IDLE);
      status.n    = active_n_ff;
      taps        = taps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         GEN_IDLE: begin
            if (start) begin
               fp_ff <= cfg.field_poly[SYM_BITS-1:0];
               es_ff <= mod_nn(16'(cfg.root_step));
               ef_ff <= mod_nn(16'(cfg.first_root));
               n_ff  <= clamp_n(cfg.parity_count);
            end
         end
         GEN_PROD: begin
            prod_ff <= PW'(es_ff) * PW'(ef_ff);
         end
         GEN_REDUCE: begin
            er_ff   <= mod_nn(16'(prod_ff));
            spow_ff <= sym_type'(1);
            root_ff <= sym_type'(1);
            k_ff    <= '0;
            i_ff    <= '0;
            taps_ff <= '0;
         end
         GEN_POW: begin
            if (k_ff < es_ff) begin
               spow_ff <= gf_xtime(spow_ff, fp_ff);
            end
            if (k_ff < er_ff) begin
               root_ff <= gf_xtime(root_ff, fp_ff);
            end
            if (!pow_done) begin
               k_ff <= k_ff + sym_type'(1);
            end
         end
         GEN_POLY: begin
            if (i_ff != n_ff) begin
               taps_ff <= taps_in;
               root_ff <= gf_mul(root_ff, spow_ff, fp_ff);
               i_ff    <= i_ff + N_BITS'(1);
            end else begin
               active_n_ff <= n_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/rsse_checker.sv =====
// Port-level checker for the Reed-Solomon encoder top, attached by bind.
// Does not depend on rsse_pkg; sees top-level ports only.
module rsse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Only a parity beat closes a codeword.
   a_last_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("tlast on a data beat");

   // While parity is still draining, no new data symbol may enter.
   a_drain_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && !rsp_tlast |-> !req_tready)
      else $error("input ready in the middle of a parity run");

   // Reset empties the output and starts the generator derivation.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block not quiet after reset");

endmodule

bind reed_solomon_systematic_encoder_top rsse_checker u_rsse_checker (.*);
